>>> rtl/lrfpf_pkg.sv
// Shared constants, register codes and the arctangent table of the point filter.
// No dependencies; imported by every module of the block.
package lrfpf_pkg;

   localparam int COORD_BITS_DEF = 18;
   localparam int CORDIC_STEPS   = 20;
   localparam int ACC_W          = 25;   // angle accumulator, 1/256 of 0.01 deg
   localparam int ANGLE_FRAC     = 8;
   localparam int RANGE_W        = 18;
   localparam int RANGE_SQ_W     = 2 * RANGE_W;
   localparam int AZ_W           = 16;
   localparam int EL_W           = 15;
   localparam int FRAMES_W       = 8;
   localparam int CNT_W          = 9;
   localparam int REFL_W         = 8;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;
   localparam logic signed [ACC_W-1:0] QUARTER_TURN = 25'sd2304000;

   localparam logic [RANGE_W-1:0]  RANGE_MIN_RST = 18'd300;
   localparam logic [RANGE_W-1:0]  RANGE_MAX_RST = 18'd3000;
   localparam logic [AZ_W-1:0]     AZ_MIN_RST    = 16'hEE6C;   // -4500
   localparam logic [AZ_W-1:0]     AZ_MAX_RST    = 16'h1194;   //  4500
   localparam logic [EL_W-1:0]     EL_MIN_RST    = 15'h6890;   // -6000
   localparam logic [EL_W-1:0]     EL_MAX_RST    = 15'h0BB8;   //  3000
   localparam logic [FRAMES_W-1:0] FRAMES_RST    = 8'd20;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANGE_MIN = 3'd0,
      CSR_RANGE_MAX = 3'd1,
      CSR_AZ_MIN    = 3'd2,
      CSR_AZ_MAX    = 3'd3,
      CSR_EL_MIN    = 3'd4,
      CSR_EL_MAX    = 3'd5,
      CSR_FRAMES    = 3'd6
   } csr_index_type;

   // atan(2^-i) in 1/256 of a hundredth of a degree, rounded
   function automatic logic signed [ACC_W-1:0] atan_step(input int unsigned i);
      logic signed [ACC_W-1:0] v;
      case (i)
         0:  v = 25'sd1152000;
         1:  v = 25'sd680065;
         2:  v = 25'sd359328;
         3:  v = 25'sd182400;
         4:  v = 25'sd91554;
         5:  v = 25'sd45822;
         6:  v = 25'sd22916;
         7:  v = 25'sd11459;
         8:  v = 25'sd5730;
         9:  v = 25'sd2865;
         10: v = 25'sd1432;
         11: v = 25'sd716;
         12: v = 25'sd358;
         13: v = 25'sd179;
         14: v = 25'sd90;
         15: v = 25'sd45;
         16: v = 25'sd22;
         17: v = 25'sd11;
         18: v = 25'sd6;
         19: v = 25'sd3;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/lidar_range_fov_point_filter.sv
// Lidar point filter: range and field-of-view test with frame-counted collection.
// Depends on lrfpf_pkg, lrfpf_isqrt and lrfpf_cordic.
//
// Usage
//   req_*  : one point per transaction (x, y, z in mm, reflectivity, frame_end).
//   rsp_*  : one result per point, in order: keep flag, the point echoed and
//            the collection-done flag after this point.
//   csr_*  : register writes by index; csr_ready is always high. Write only
//            while the pipe is empty.
// Pipeline: COORD_BITS + 25 register stages (43 at 18 bits): input register,
//   squares, sum and range compare, COORD_BITS + 1 square root stages,
//   20 CORDIC stages, output register.
// Throughput: one point per cycle when not stalled. The pipe moves as one;
//   the only hold point is the output register, so req_ready =
//   !rsp_valid || rsp_ready.
// A stalled receiver freezes every stage; nothing is dropped or repeated.
// Reset (synchronous): registers go to their defaults, frame count and done
//   clear, all stage valid bits clear. No clearing pass is needed.
// Frame counting and done are resolved at the output register, so the
//   feedback loop closes within that register stage.
module lidar_range_fov_point_filter #(
   parameter int COORD_BITS = lrfpf_pkg::COORD_BITS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // request
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [COORD_BITS-1:0]           req_x_mm,
   input  logic signed [COORD_BITS-1:0]           req_y_mm,
   input  logic signed [COORD_BITS-1:0]           req_z_mm,
   input  logic [lrfpf_pkg::REFL_W-1:0]           req_reflectivity,
   input  logic                                   req_frame_end,
   // response
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_keep_point,
   output logic signed [COORD_BITS-1:0]           rsp_out_x_mm,
   output logic signed [COORD_BITS-1:0]           rsp_out_y_mm,
   output logic signed [COORD_BITS-1:0]           rsp_out_z_mm,
   output logic [lrfpf_pkg::REFL_W-1:0]           rsp_out_reflectivity,
   output logic                                   rsp_collection_done,
   // register writes
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [lrfpf_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  logic [lrfpf_pkg::CSR_DATA_W-1:0]       csr_data
);
   import lrfpf_pkg::*;

   localparam int W    = COORD_BITS;
   localparam int XW   = W + 4;             // CORDIC datapath, covers gain
   localparam int NSQ  = W + 1;             // square root stages
   localparam int RCW  = (2 * W + 2 > RANGE_SQ_W) ? 2 * W + 2 : RANGE_SQ_W;
   localparam int SW   = 3 * W + REFL_W + 2; // x, y, z, refl, frame_end, range ok
   localparam int SBW  = SW + 2;             // plus the two zero-vector flags

   // ---------------- configuration ----------------
   logic [RANGE_W-1:0]    range_min_ff, range_max_ff;
   logic signed [AZ_W-1:0] az_min_ff, az_max_ff;
   logic signed [EL_W-1:0] el_min_ff, el_max_ff;
   logic [FRAMES_W-1:0]   frames_ff;
   logic [RANGE_SQ_W-1:0] rmin_sq_ff, rmax_sq_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_min_ff <= RANGE_MIN_RST;
         range_max_ff <= RANGE_MAX_RST;
         az_min_ff    <= AZ_MIN_RST;
         az_max_ff    <= AZ_MAX_RST;
         el_min_ff    <= EL_MIN_RST;
         el_max_ff    <= EL_MAX_RST;
         frames_ff    <= FRAMES_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_RANGE_MIN: range_min_ff <= csr_data[RANGE_W-1:0];
            CSR_RANGE_MAX: range_max_ff <= csr_data[RANGE_W-1:0];
            CSR_AZ_MIN:    az_min_ff    <= csr_data[AZ_W-1:0];
            CSR_AZ_MAX:    az_max_ff    <= csr_data[AZ_W-1:0];
            CSR_EL_MIN:    el_min_ff    <= csr_data[EL_W-1:0];
            CSR_EL_MAX:    el_max_ff    <= csr_data[EL_W-1:0];
            CSR_FRAMES:    frames_ff    <= csr_data[FRAMES_W-1:0];
            default: ;
         endcase
      end
   end

   // squared range bounds, registered from the range registers
   always_ff @(posedge clock) begin
      rmin_sq_ff <= RANGE_SQ_W'(range_min_ff) * RANGE_SQ_W'(range_min_ff);
      rmax_sq_ff <= RANGE_SQ_W'(range_max_ff) * RANGE_SQ_W'(range_max_ff);
   end

   // whole pipe advances unless the output holds an untaken result
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: input register, magnitudes ----------------
   logic                   v1_ff;
   logic signed [W-1:0]    x1_ff, y1_ff, z1_ff;
   logic [W-1:0]           ax1_ff, ay1_ff, az1_ff;
   logic [REFL_W-1:0]      refl1_ff;
   logic                   fend1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (adv) v1_ff <= req_valid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff    <= req_x_mm;
         y1_ff    <= req_y_mm;
         z1_ff    <= req_z_mm;
         ax1_ff   <= req_x_mm[W-1] ? W'(-req_x_mm) : W'(req_x_mm);
         ay1_ff   <= req_y_mm[W-1] ? W'(-req_y_mm) : W'(req_y_mm);
         az1_ff   <= req_z_mm[W-1] ? W'(-req_z_mm) : W'(req_z_mm);
         refl1_ff <= req_reflectivity;
         fend1_ff <= req_frame_end;
      end
   end

   // ---------------- stage 2: squares ----------------
   logic                   v2_ff;
   logic [2*W-1:0]         sqx2_ff, sqy2_ff, sqz2_ff;
   logic signed [W-1:0]    x2_ff, y2_ff, z2_ff;
   logic [REFL_W-1:0]      refl2_ff;
   logic                   fend2_ff;

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (adv) v2_ff <= v1_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         sqx2_ff  <= (2*W)'(ax1_ff) * (2*W)'(ax1_ff);
         sqy2_ff  <= (2*W)'(ay1_ff) * (2*W)'(ay1_ff);
         sqz2_ff  <= (2*W)'(az1_ff) * (2*W)'(az1_ff);
         x2_ff    <= x1_ff;
         y2_ff    <= y1_ff;
         z2_ff    <= z1_ff;
         refl2_ff <= refl1_ff;
         fend2_ff <= fend1_ff;
      end
   end

   // ---------------- stage 3: planar sum, range test ----------------
   logic                   v3_ff;
   logic [2*W:0]           planar_in, planar_ff;
   logic [2*W+1:0]         r2_in;
   logic                   rng_in;
   logic [SW-1:0]          side3_ff;

   always_comb begin
      planar_in = (2*W+1)'(sqx2_ff) + (2*W+1)'(sqy2_ff);
      r2_in     = (2*W+2)'(planar_in) + (2*W+2)'(sqz2_ff);
      rng_in    = (RCW'(r2_in) > RCW'(rmin_sq_ff)) && (RCW'(r2_in) < RCW'(rmax_sq_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (adv) v3_ff <= v2_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         planar_ff <= planar_in;
         side3_ff  <= {rng_in, fend2_ff, refl2_ff, z2_ff, y2_ff, x2_ff};
      end
   end

   // ---------------- square root stages ----------------
   logic [W-1:0]  rho;
   logic [SW-1:0] side_a_ff [NSQ];
   logic          va_ff     [NSQ];

   lrfpf_isqrt #(.COORD_BITS(COORD_BITS)) u_isqrt (
      .clock    (clock),
      .en       (adv),
      .radicand (planar_ff),
      .root     (rho)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSQ; i++) va_ff[i] <= 1'b0;
      end else if (adv) begin
         va_ff[0] <= v3_ff;
         for (int i = 1; i < NSQ; i++) va_ff[i] <= va_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_a_ff[0] <= side3_ff;
         for (int i = 1; i < NSQ; i++) side_a_ff[i] <= side_a_ff[i-1];
      end
   end

   // ---------------- CORDIC entry ----------------
   logic signed [W-1:0]     xa, ya, za;
   logic signed [XW-1:0]    xe, ye, az_x0, az_y0, el_x0, el_y0;
   logic signed [ACC_W-1:0] az_acc0, az_angle_raw, el_angle_raw;
   logic                    az_zero, el_zero;

   assign xa = side_a_ff[NSQ-1][W-1:0];
   assign ya = side_a_ff[NSQ-1][2*W-1:W];
   assign za = side_a_ff[NSQ-1][3*W-1:2*W];

   // quarter-turn pre-rotation brings the left half-plane into range
   always_comb begin
      xe = XW'(xa);
      ye = XW'(ya);
      if (!xa[W-1]) begin
         az_x0 = xe;   az_y0 = ye;   az_acc0 = '0;
      end else if (!ya[W-1]) begin
         az_x0 = ye;   az_y0 = -xe;  az_acc0 = QUARTER_TURN;
      end else begin
         az_x0 = -ye;  az_y0 = xe;   az_acc0 = -QUARTER_TURN;
      end
      el_x0   = $signed(XW'(rho));
      el_y0   = XW'(za);
      az_zero = (xa == '0) && (ya == '0);
      el_zero = (rho == '0) && (za == '0);
   end

   lrfpf_cordic #(.XW(XW)) u_cordic_az (
      .clock     (clock),
      .en        (adv),
      .x_start   (az_x0),
      .y_start   (az_y0),
      .acc_start (az_acc0),
      .angle     (az_angle_raw)
   );

   lrfpf_cordic #(.XW(XW)) u_cordic_el (
      .clock     (clock),
      .en        (adv),
      .x_start   (el_x0),
      .y_start   (el_y0),
      .acc_start ('0),
      .angle     (el_angle_raw)
   );

   logic [SBW-1:0] side_b_ff [CORDIC_STEPS];
   logic           vb_ff     [CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CORDIC_STEPS; i++) vb_ff[i] <= 1'b0;
      end else if (adv) begin
         vb_ff[0] <= va_ff[NSQ-1];
         for (int i = 1; i < CORDIC_STEPS; i++) vb_ff[i] <= vb_ff[i-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side_b_ff[0] <= {az_zero, el_zero, side_a_ff[NSQ-1]};
         for (int i = 1; i < CORDIC_STEPS; i++) side_b_ff[i] <= side_b_ff[i-1];
      end
   end

   // ---------------- tail: bounds, frame count, output register ----------------
   logic [SBW-1:0]          sb;
   logic                    vb_last, fend_b, rng_b;
   logic signed [ACC_W-1:0] az_angle, el_angle;
   logic signed [ACC_W-1:0] az_lo, az_hi, el_lo, el_hi;
   logic                    pass;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic                    done_ff, done_in;

   assign sb       = side_b_ff[CORDIC_STEPS-1];
   assign vb_last  = vb_ff[CORDIC_STEPS-1];
   assign rng_b    = sb[SW-1];
   assign fend_b   = sb[SW-2];
   assign az_angle = sb[SBW-1] ? '0 : az_angle_raw;
   assign el_angle = sb[SBW-2] ? '0 : el_angle_raw;

   // bounds scaled by 256 to the accumulator's units
   assign az_lo = $signed({{(ACC_W-AZ_W-ANGLE_FRAC){az_min_ff[AZ_W-1]}}, az_min_ff,
                           ANGLE_FRAC'(0)});
   assign az_hi = $signed({{(ACC_W-AZ_W-ANGLE_FRAC){az_max_ff[AZ_W-1]}}, az_max_ff,
                           ANGLE_FRAC'(0)});
   assign el_lo = $signed({{(ACC_W-EL_W-ANGLE_FRAC){el_min_ff[EL_W-1]}}, el_min_ff,
                           ANGLE_FRAC'(0)});
   assign el_hi = $signed({{(ACC_W-EL_W-ANGLE_FRAC){el_max_ff[EL_W-1]}}, el_max_ff,
                           ANGLE_FRAC'(0)});

   assign pass = rng_b && (az_angle > az_lo) && (az_angle < az_hi) &&
                 (el_angle > el_lo) && (el_angle < el_hi);

   // saturating frame count; done is sticky and freezes the count
   always_comb begin
      count_in = count_ff;
      done_in  = done_ff;
      if (vb_last && !done_ff && fend_b) begin
         if (count_ff != COUNT_MAX) count_in = count_ff + 1'b1;
         if (count_in > {1'b0, frames_ff}) done_in = 1'b1;
      end
   end

   logic                   keep_ff, cdone_ff;
   logic signed [W-1:0]    xo_ff, yo_ff, zo_ff;
   logic [REFL_W-1:0]      reflo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         done_ff      <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= vb_last;
         count_ff     <= count_in;
         done_ff      <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         keep_ff  <= pass && !done_ff;
         cdone_ff <= done_in;
         xo_ff    <= sb[W-1:0];
         yo_ff    <= sb[2*W-1:W];
         zo_ff    <= sb[3*W-1:2*W];
         reflo_ff <= sb[3*W+REFL_W-1:3*W];
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_keep_point       = keep_ff;
   assign rsp_out_x_mm         = xo_ff;
   assign rsp_out_y_mm         = yo_ff;
   assign rsp_out_z_mm         = zo_ff;
   assign rsp_out_reflectivity = reflo_ff;
   assign rsp_collection_done  = cdone_ff;

   // ---------------- assertions ----------------
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> done_ff)
      else $error("done flag cleared without reset");

   a_done_rise: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && $rose(done_ff) |-> (count_ff > {1'b0, frames_ff}))
      else $error("done raised before frame count exceeded limit");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(count_ff) |-> $past(adv && vb_last && fend_b && !done_ff))
      else $error("frame count moved without a frame end transaction");

   // a held response keeps its payload until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_keep_point)
         && $stable(rsp_out_x_mm) && $stable(rsp_collection_done))
      else $error("response changed while stalled");

endmodule

>>> rtl/lrfpf_isqrt.sv
// Pipelined integer square root, one result bit per register stage.
// Depends on lrfpf_pkg.
module lrfpf_isqrt #(
   parameter int COORD_BITS = lrfpf_pkg::COORD_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [2*COORD_BITS:0]   radicand,
   output logic [COORD_BITS-1:0]   root
);
   import lrfpf_pkg::*;

   localparam int NS  = COORD_BITS + 1;
   localparam int RW  = 2 * NS;
   localparam int RMW = COORD_BITS + 4;
   localparam int QW  = COORD_BITS + 1;

   logic [RW-1:0]  rad_ff  [NS];
   logic [RMW-1:0] rem_ff  [NS];
   logic [QW-1:0]  root_ff [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         logic [RW-1:0]  rad_p, rad_in;
         logic [RMW-1:0] rem_p, rem_sh, trial, rem_in;
         logic [QW-1:0]  root_p, root_in;

         if (k == 0) begin : g_first
            assign rad_p  = {1'b0, radicand};
            assign rem_p  = '0;
            assign root_p = '0;
         end else begin : g_next
            assign rad_p  = rad_ff[k-1];
            assign rem_p  = rem_ff[k-1];
            assign root_p = root_ff[k-1];
         end

         always_comb begin
            rem_sh = {rem_p[RMW-3:0], rad_p[RW-1:RW-2]};
            trial  = RMW'({root_p, 2'b01});
            rad_in = {rad_p[RW-3:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_p[QW-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_p[QW-2:0], 1'b0};
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rad_ff[k]  <= rad_in;
               rem_ff[k]  <= rem_in;
               root_ff[k] <= root_in;
            end
         end
      end
   endgenerate

   assign root = root_ff[NS-1][COORD_BITS-1:0];

endmodule

>>> rtl/lrfpf_cordic.sv
// Pipelined CORDIC in vectoring mode, one micro-rotation per register stage.
// Depends on lrfpf_pkg for the step count and the arctangent table.
module lrfpf_cordic #(
   parameter int XW = lrfpf_pkg::COORD_BITS_DEF + 4
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic signed [XW-1:0]                x_start,
   input  logic signed [XW-1:0]                y_start,
   input  logic signed [lrfpf_pkg::ACC_W-1:0]  acc_start,
   output logic signed [lrfpf_pkg::ACC_W-1:0]  angle
);
   import lrfpf_pkg::*;

   logic signed [XW-1:0]    x_ff   [CORDIC_STEPS];
   logic signed [XW-1:0]    y_ff   [CORDIC_STEPS];
   logic signed [ACC_W-1:0] acc_ff [CORDIC_STEPS];

   genvar i;
   generate
      for (i = 0; i < CORDIC_STEPS; i++) begin : g_step
         logic signed [XW-1:0]    xp, yp, x_in, y_in;
         logic signed [ACC_W-1:0] ap, acc_in;

         if (i == 0) begin : g_first
            assign xp = x_start;
            assign yp = y_start;
            assign ap = acc_start;
         end else begin : g_next
            assign xp = x_ff[i-1];
            assign yp = y_ff[i-1];
            assign ap = acc_ff[i-1];
         end

         always_comb begin
            if (!yp[XW-1]) begin
               x_in   = xp + (yp >>> i);
               y_in   = yp - (xp >>> i);
               acc_in = ap + atan_step(i);
            end else begin
               x_in   = xp - (yp >>> i);
               y_in   = yp + (xp >>> i);
               acc_in = ap - atan_step(i);
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               x_ff[i]   <= x_in;
               y_ff[i]   <= y_in;
               acc_ff[i] <= acc_in;
            end
         end
      end
   endgenerate

   assign angle = acc_ff[CORDIC_STEPS-1];

endmodule

>>> dv/lidar_range_fov_point_filter_tb.sv
// Self-checking testbench for lidar_range_fov_point_filter: directed table, then random phases.
// Depends on lrfpf_pkg and the RTL of the block; nothing else.
`timescale 1ns / 1ps

module lidar_range_fov_point_filter_tb;
   import lrfpf_pkg::*;

   localparam int CW         = COORD_BITS_DEF;
   localparam int WDOG_LIMIT = 3000;   // cycles with no transaction anywhere
   localparam int DRAIN_WAIT = 60;     // a little over the 43-stage pipe
   localparam int PHASE_PTS  = 290;
   localparam longint ANG1   = 256;    // accumulator units per 0.01 deg
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 3'd7;

   // atan(2^-i), 1/256 of 0.01 deg
   localparam longint ATAN_TAB [CORDIC_STEPS] = '{
      1152000, 680065, 359328, 182400, 91554, 45822, 22916, 11459, 5730, 2865,
      1432, 716, 358, 179, 90, 45, 22, 11, 6, 3};

   typedef struct {
      logic signed [CW-1:0] x, y, z;
      logic [REFL_W-1:0]    refl;
      logic                 fend;
   } point_type;

   typedef struct {
      logic                 keep;
      logic signed [CW-1:0] x, y, z;
      logic [REFL_W-1:0]    refl;
      logic                 done;
   } verdict_type;

   // directed row: typed keep/done only where obvious
   typedef struct {
      point_type pt;
      bit        typed;
      logic      keep;
      logic      done;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset;
   logic req_valid, req_ready, req_frame_end;
   logic signed [CW-1:0] req_x_mm, req_y_mm, req_z_mm;
   logic [REFL_W-1:0] req_reflectivity;
   logic rsp_valid, rsp_ready, rsp_keep_point, rsp_collection_done;
   logic signed [CW-1:0] rsp_out_x_mm, rsp_out_y_mm, rsp_out_z_mm;
   logic [REFL_W-1:0] rsp_out_reflectivity;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_data;

   always #5 clock = ~clock;

   lidar_range_fov_point_filter uut (.*);

   // shadow of the block's registers and collection state
   logic [RANGE_W-1:0]        lim_rng_min, lim_rng_max;
   logic signed [AZ_W-1:0]    lim_az_min, lim_az_max;
   logic signed [EL_W-1:0]    lim_el_min, lim_el_max;
   logic [FRAMES_W-1:0]       lim_frames;
   logic [CNT_W-1:0]          frames_seen;
   logic                      collect_done;

   verdict_type expected_q[$];
   dir_row_type dir_rows[$];
   int send_idle, recv_idle;
   int n_err, n_pts, n_rsp, n_kept, n_done_rsp, n_csr;
   int quiet_cycles;

   task automatic report(string field, longint got, longint want);
      n_err++;
      $display("MISMATCH rsp #%0d %s: got %0d, want %0d", n_rsp, field, got, want);
   endtask

   function automatic longint cordic_vec(longint x, longint y, longint acc);
      longint xs, ys;
      for (int i = 0; i < CORDIC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x += ys; y -= xs; acc += ATAN_TAB[i];
         end else begin
            x -= ys; y += xs; acc -= ATAN_TAB[i];
         end
      end
      return acc;
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res  = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v  -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   // keep/done verdict for one point; advances the frame counter
   function automatic verdict_type filter_point(point_type p);
      verdict_type v;
      longint x, y, z, ax, ay, az, planar2, r2, azim, elev, rho;
      x = p.x; y = p.y; z = p.z;
      v.keep = 1'b0;
      if (!collect_done) begin
         ax = x < 0 ? -x : x;
         ay = y < 0 ? -y : y;
         az = z < 0 ? -z : z;
         planar2 = ax * ax + ay * ay;
         r2 = planar2 + az * az;
         if (x == 0 && y == 0)  azim = 0;
         else if (x >= 0)       azim = cordic_vec(x, y, 0);
         else if (y >= 0)       azim = cordic_vec(y, -x, 9000 * ANG1);
         else                   azim = cordic_vec(-y, x, -9000 * ANG1);
         rho  = longint'(int_sqrt(planar2));
         elev = (rho == 0 && z == 0) ? 0 : cordic_vec(rho, z, 0);
         v.keep = r2 > longint'(lim_rng_min) * longint'(lim_rng_min) &&
                  r2 < longint'(lim_rng_max) * longint'(lim_rng_max) &&
                  azim > longint'(lim_az_min) * ANG1 && azim < longint'(lim_az_max) * ANG1 &&
                  elev > longint'(lim_el_min) * ANG1 && elev < longint'(lim_el_max) * ANG1;
         if (p.fend) begin
            if (frames_seen != COUNT_MAX) frames_seen++;
            if (frames_seen > {1'b0, lim_frames}) collect_done = 1'b1;
         end
      end
      v.x = p.x; v.y = p.y; v.z = p.z; v.refl = p.refl;
      v.done = collect_done;
      return v;
   endfunction

   // one register write transaction; shadow updated on acceptance.
   // valid stays up for back-to-back writes; the caller lowers it after the last
   task automatic write_reg(csr_index_type idx, int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      n_csr++;
      case (idx)
         CSR_RANGE_MIN: lim_rng_min = value[RANGE_W-1:0];
         CSR_RANGE_MAX: lim_rng_max = value[RANGE_W-1:0];
         CSR_AZ_MIN:    lim_az_min  = value[AZ_W-1:0];
         CSR_AZ_MAX:    lim_az_max  = value[AZ_W-1:0];
         CSR_EL_MIN:    lim_el_min  = value[EL_W-1:0];
         CSR_EL_MAX:    lim_el_max  = value[EL_W-1:0];
         CSR_FRAMES:    lim_frames  = value[FRAMES_W-1:0];
         default: ;
      endcase
   endtask

   // wait for the pipe to empty, then let it settle before touching registers
   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   // one point transaction; valid stays up across back-to-back points
   task automatic send_point(point_type p, bit typed, logic tkeep, logic tdone);
      verdict_type v;
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle);
      end
      req_valid        <= 1'b1;
      req_x_mm         <= p.x;
      req_y_mm         <= p.y;
      req_z_mm         <= p.z;
      req_reflectivity <= p.refl;
      req_frame_end    <= p.fend;
      do @(posedge clock); while (!req_ready);
      v = filter_point(p);
      if (typed) begin
         if (v.keep !== tkeep || v.done !== tdone)
            $display("NOTE: table row %0d differs from predictor", n_pts);
         v.keep = tkeep;
         v.done = tdone;
      end
      expected_q = {expected_q, v};
      n_pts++;
   endtask

   function automatic logic signed [CW-1:0] rand_coord(int shape);
      case (shape)
         0:       return CW'($urandom_range(7000) - 3500);
         1:       return CW'($urandom);
         2:       return CW'($urandom_range(4) - 2);
         default: return 0;
      endcase
   endfunction

   // mostly points around the sensible field of view, some full-scale noise
   function automatic point_type rand_point(int fend_pct);
      point_type p;
      int shape;
      shape = $urandom_range(9);
      shape = shape < 6 ? 0 : (shape < 8 ? 1 : 2);
      p.x = rand_coord(shape);
      p.y = rand_coord(($urandom_range(7) == 0) ? 3 : shape);
      p.z = rand_coord(($urandom_range(7) == 0) ? 3 : shape);
      if ($urandom_range(9) == 0) p.x = rand_coord(3);
      p.refl = REFL_W'($urandom);
      p.fend = $urandom_range(99) < fend_pct;
      return p;
   endfunction

   function automatic void add_row(int x, int y, int z, int refl, bit fend,
                                   bit typed, logic k, logic d);
      dir_row_type r;
      r.pt.x = CW'(x); r.pt.y = CW'(y); r.pt.z = CW'(z);
      r.pt.refl = REFL_W'(refl); r.pt.fend = fend;
      r.typed = typed; r.keep = k; r.done = d;
      dir_rows = {dir_rows, r};
   endfunction

   // result checker, receiver stalls and the watchdog
   always @(posedge clock) begin
      verdict_type w;
      if (reset) begin
         rsp_ready    <= 1'b0;
         quiet_cycles <= 0;
      end else begin
         rsp_ready <= $urandom_range(99) >= recv_idle;
         if ((req_valid && req_ready) || (csr_valid && csr_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
         else
            quiet_cycles <= quiet_cycles + 1;
         if (rsp_valid && rsp_ready) begin
            if (expected_q.size() == 0) begin
               report("unexpected response, x_mm", rsp_out_x_mm, 0);
            end else begin
               w = expected_q.pop_front();
               if (rsp_keep_point !== w.keep)      report("keep_point", rsp_keep_point, w.keep);
               if (rsp_out_x_mm !== w.x)            report("x_mm", rsp_out_x_mm, w.x);
               if (rsp_out_y_mm !== w.y)            report("y_mm", rsp_out_y_mm, w.y);
               if (rsp_out_z_mm !== w.z)            report("z_mm", rsp_out_z_mm, w.z);
               if (rsp_out_reflectivity !== w.refl)
                  report("reflectivity", rsp_out_reflectivity, w.refl);
               if (rsp_collection_done !== w.done)
                  report("collection_done", rsp_collection_done, w.done);
               n_kept     += (rsp_keep_point === 1'b1);
               n_done_rsp += (rsp_collection_done === 1'b1);
            end
            n_rsp++;
         end
         if (quiet_cycles >= WDOG_LIMIT) begin
            $display("TIMEOUT: no transaction for %0d cycles", WDOG_LIMIT);
            $display("lidar_range_fov_point_filter verification failed");
            $finish;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0; req_x_mm = '0; req_y_mm = '0; req_z_mm = '0;
      req_reflectivity = '0; req_frame_end = 1'b0;
      csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      send_idle = 11; recv_idle = 62;
      n_err = 0; n_pts = 0; n_rsp = 0; n_kept = 0; n_done_rsp = 0; n_csr = 0;
      // reset state of the shadow
      lim_rng_min = 18'd300;  lim_rng_max = 18'd3000;
      lim_az_min = -16'sd4500; lim_az_max = 16'sd4500;
      lim_el_min = -15'sd6000; lim_el_max = 15'sd3000;
      lim_frames = 8'd20; frames_seen = '0; collect_done = 1'b0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed table at reset settings: axes, range edges, full-scale corners
      add_row(1000, 0, 0, 0, 0, 1, 1, 0);
      add_row(0, 0, 0, 255, 0, 1, 0, 0);                  // zero vector
      add_row(1000, 1000, 0, 1, 0, 0, 0, 0);             // on the azimuth bound
      add_row(-1000, 0, 0, 2, 0, 1, 0, 0);               // straight behind
      add_row(0, 1000, 0, 3, 0, 1, 0, 0);
      add_row(0, -1000, 0, 4, 1, 1, 0, 0);
      add_row(-1000, -1, 0, 5, 0, 1, 0, 0);              // behind, just below axis
      add_row(-1000, 1, 0, 6, 0, 0, 0, 0);
      add_row(131071, 131071, 131071, 170, 0, 1, 0, 0);
      add_row(-131072, -131072, -131072, 85, 1, 1, 0, 0);
      add_row(1000, 0, 1000, 7, 0, 1, 0, 0);             // elevation too high
      add_row(1000, 0, -1000, 8, 0, 1, 1, 0);
      add_row(0, 0, 1000, 9, 0, 1, 0, 0);
      add_row(0, 0, -1000, 10, 0, 1, 0, 0);
      add_row(299, 0, 0, 11, 0, 1, 0, 0);                // range edges, strict
      add_row(300, 0, 0, 12, 0, 1, 0, 0);
      add_row(301, 0, 0, 13, 0, 1, 1, 0);
      add_row(2999, 0, 0, 14, 0, 1, 1, 0);
      add_row(3000, 0, 0, 15, 1, 1, 0, 0);
      add_row(2000, 1500, -1200, 16, 0, 0, 0, 0);
      add_row(1, -1, 1, 17, 0, 0, 0, 0);
      foreach (dir_rows[i])
         send_point(dir_rows[i].pt, dir_rows[i].typed, dir_rows[i].keep, dir_rows[i].done);
      req_valid <= 1'b0;

      // random phases, each with its own register setting
      for (int ph = 0; ph < 6; ph++) begin
         drain();
         case (ph / 2)
            0: begin send_idle = 11; recv_idle = 62; end
            1: begin send_idle = 62; recv_idle = 11; end
            default: begin send_idle = 0; recv_idle = 0; end
         endcase
         case (ph)
            0: begin  // widest window
               write_reg(CSR_RANGE_MIN, 0);       write_reg(CSR_RANGE_MAX, 262143);
               write_reg(CSR_AZ_MIN, -18000);     write_reg(CSR_AZ_MAX, 18000);
               write_reg(CSR_EL_MIN, -9000);      write_reg(CSR_EL_MAX, 9000);
               write_reg(CSR_FRAMES, 255);
            end
            2: begin  // equal and reversed bounds: nothing kept
               write_reg(CSR_RANGE_MIN, 2000);    write_reg(CSR_RANGE_MAX, 2000);
               write_reg(CSR_AZ_MIN, 3000);       write_reg(CSR_AZ_MAX, -3000);
               write_reg(CSR_EL_MIN, 9000);       write_reg(CSR_EL_MAX, -9000);
               write_reg(csr_index_type'(CSR_UNMAPPED), 32'hFFFF_FFFF);
            end
            default: begin
               write_reg(CSR_RANGE_MIN, $urandom_range(1500));
               write_reg(CSR_RANGE_MAX, $urandom_range(6000, 1500));
               write_reg(CSR_AZ_MIN, $urandom_range(18000) - 18000);
               write_reg(CSR_AZ_MAX, $urandom_range(18000));
               write_reg(CSR_EL_MIN, $urandom_range(9000) - 9000);
               write_reg(CSR_EL_MAX, $urandom_range(9000));
               // last phase: zero frames, so the next frame end finishes collection
               write_reg(CSR_FRAMES, ph == 5 ? 0 : 255);
            end
         endcase
         csr_valid <= 1'b0;
         for (int k = 0; k < PHASE_PTS; k++) begin
            if (ph == 1 && k == PHASE_PTS / 2) begin
               // sender holds off until the pipe is empty
               req_valid <= 1'b0;
               while (expected_q.size() != 0) @(posedge clock);
               @(posedge clock);
            end
            send_point(rand_point(2), 0, 1'b0, 1'b0);
         end
         req_valid <= 1'b0;
      end
      // done is sticky: a fresh frame count target must not clear it
      drain();
      write_reg(CSR_FRAMES, 255);
      csr_valid <= 1'b0;
      repeat (20) send_point(rand_point(20), 0, 1'b0, 1'b0);
      req_valid <= 1'b0;
      drain();

      $display("Covered %0d points (%0d kept, %0d after done), %0d register writes,",
               n_pts, n_kept, n_done_rsp, n_csr);
      $display("six register settings and three stall profiles; %0d mismatches.", n_err);
      if (n_err == 0 && expected_q.size() == 0)
         $display("lidar_range_fov_point_filter verification clean");
      else
         $display("lidar_range_fov_point_filter verification failed");
      $finish;
   end

endmodule

>>> sim.f
rtl/lrfpf_pkg.sv
rtl/lrfpf_isqrt.sv
rtl/lrfpf_cordic.sv
rtl/lidar_range_fov_point_filter.sv
dv/lidar_range_fov_point_filter_tb.sv
